FILE: src/cbca_pkg.sv
// Shared types and constants of the capacity-bounded cluster assignment block.
package cbca_pkg;

  localparam int MaxClusters = 64;
  localparam int FeatureDim  = 32;
  localparam int CW = $clog2(MaxClusters);
  localparam int DW = $clog2(FeatureDim);
  localparam int AccW  = 36;
  localparam int LoadW = 32;
  localparam int ValW  = 16;
  localparam int NnzW  = 24;
  localparam int PrevW = 7;

  typedef enum logic [1:0] {
    OP_LOAD_CENTROID = 2'd0,
    OP_START_PASS    = 2'd1,
    OP_FEATURE       = 2'd2,
    OP_UNUSED        = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_NUM_CLUSTERS = 2'd0,
    CFG_MIN_CAPACITY = 2'd1,
    CFG_MAX_CAPACITY = 2'd2,
    CFG_NONE         = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_SELECT,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic start_acc;
    logic start_sel;
    logic commit;
  } cbca_cmd_t;

  typedef struct packed {
    logic acc_done;
    logic sel_done;
    logic col_last;
    logic out_busy;
  } cbca_sts_t;

endpackage

FILE: src/cbca_ctrl.sv
// Controller state machine: sequences accumulation, selection and commit of a column.
module cbca_ctrl import cbca_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_accept,
  input  opcode_t   opcode,
  input  cbca_sts_t sts,
  output logic      in_ready,
  output cbca_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && opcode == OP_FEATURE) state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        if (sts.acc_done) state_next = sts.col_last ? ST_SELECT : ST_IDLE;
      end
      ST_SELECT: begin
        if (sts.sel_done) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!sts.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.start_acc = 1'b0;
    cmd.start_sel = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.start_acc = in_accept && opcode == OP_FEATURE;
      end
      ST_ACCUM:  cmd.start_sel = sts.acc_done && sts.col_last;
      ST_SELECT: ;
      ST_COMMIT: cmd.commit = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

FILE: src/cbca_dp.sv
// Datapath: centroid, accumulator and load memories, distance pipeline and selection scan.
module cbca_dp import cbca_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_accept,
  input  opcode_t          opcode,
  input  logic [CW-1:0]    cluster_index,
  input  logic [DW-1:0]    dim_index,
  input  logic [ValW-1:0]  element_value,
  input  logic [NnzW-1:0]  column_nnz,
  input  logic [PrevW-1:0] previous_cluster,
  input  logic             last_element,
  input  logic [6:0]       num_clusters,
  input  logic [LoadW-1:0] min_capacity,
  input  logic [LoadW-1:0] max_capacity,
  input  cbca_cmd_t        cmd,
  output cbca_sts_t        sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CW-1:0]    chosen_cluster,
  output logic             changed,
  output logic             any_changed,
  output logic             forced,
  output logic [LoadW-1:0] cluster_load
);

  logic [ValW-1:0]  cen_mem  [MaxClusters*FeatureDim];
  logic [AccW-1:0]  acc_mem  [MaxClusters];
  logic [LoadW-1:0] load_mem [MaxClusters];
  logic [MaxClusters-1:0] acc_vld;
  logic [MaxClusters-1:0] load_vld;

  // Column item held while it is worked on.
  logic [DW-1:0]    dim;
  logic [ValW-1:0]  feat;
  logic [NnzW-1:0]  nnz;
  logic [PrevW-1:0] prev;
  logic             col_last;

  logic          run, mode_sel;
  logic [CW-1:0] cnt, last_idx, k_last;
  logic          p1, p1_sel;
  logic [CW-1:0] p1c;
  logic [ValW-1:0]  cen_q;
  logic [AccW-1:0]  acc_q;
  logic [LoadW-1:0] load_q;
  logic             acc_v_q, load_v_q;
  logic             p2;
  logic [CW-1:0]    c2;
  logic [32:0]      sq;
  logic [AccW-1:0]  acc2;

  logic             found;
  logic [CW-1:0]    best_idx, min_idx;
  logic [AccW+1:0]  best_cost;
  logic [LoadW-1:0] best_load, min_load;
  logic             pass_flag;

  logic [AccW-1:0]  acc_rd;
  logic [LoadW-1:0] load_rd;
  logic             fits;
  logic [AccW+1:0]  cost;
  logic signed [ValW:0]   diff;
  logic signed [2*ValW+1:0] prod;
  logic [AccW:0]    acc_sum;
  logic [CW-1:0]    pick;
  logic [LoadW-1:0] pick_load;
  logic [LoadW:0]   new_sum;
  logic             is_changed;

  always_comb begin
    if (num_clusters == 7'd0) k_last = '0;
    else if (num_clusters > 7'(MaxClusters)) k_last = CW'(MaxClusters - 1);
    else k_last = CW'(num_clusters - 7'd1);
  end
  assign last_idx = mode_sel ? k_last : CW'(MaxClusters - 1);

  always_ff @(posedge clk) begin
    if (in_accept && opcode == OP_LOAD_CENTROID) begin
      cen_mem[{cluster_index, dim_index}] <= element_value;
    end
    if (in_accept && opcode == OP_FEATURE) begin
      dim      <= dim_index;
      feat     <= element_value;
      nnz      <= column_nnz;
      prev     <= previous_cluster;
      col_last <= last_element;
    end
  end

  // Issue counter walks the clusters, once per feature element and once per selection.
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      mode_sel <= 1'b0;
      cnt <= '0;
    end else if (cmd.start_acc || cmd.start_sel) begin
      run <= 1'b1;
      mode_sel <= cmd.start_sel;
      cnt <= '0;
    end else if (run) begin
      cnt <= cnt + CW'(1);
      if (cnt == last_idx) run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
    end else begin
      p1 <= run;
      p2 <= p1 && !p1_sel;
    end
  end

  always_ff @(posedge clk) begin
    p1_sel   <= mode_sel;
    p1c      <= cnt;
    cen_q    <= cen_mem[{cnt, dim}];
    acc_q    <= acc_mem[cnt];
    acc_v_q  <= acc_vld[cnt];
    load_q   <= load_mem[cnt];
    load_v_q <= load_vld[cnt];
  end

  assign acc_rd  = acc_v_q ? acc_q : '0;
  assign load_rd = load_v_q ? load_q : '0;
  assign diff = $signed({1'b0, feat}) - $signed({1'b0, cen_q});
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    sq   <= prod[32:0];
    acc2 <= acc_rd;
    c2   <= p1c;
  end

  assign acc_sum = {1'b0, acc2} + (AccW + 1)'(sq);

  always_ff @(posedge clk) begin
    if (p2) acc_mem[c2] <= acc_sum[AccW] ? {AccW{1'b1}} : acc_sum[AccW-1:0];
  end

  assign fits = ({1'b0, load_rd} + (LoadW + 1)'(nnz)) <= {1'b0, max_capacity};
  assign cost = (load_rd >= min_capacity) ? {acc_rd, 2'b00} : {2'b00, acc_rd};

  // Selection scan: lowest-cost cluster with room, and the least-loaded one as fallback.
  always_ff @(posedge clk) begin
    if (cmd.start_sel) begin
      found <= 1'b0;
    end else if (p1 && p1_sel) begin
      if (fits && (!found || cost < best_cost)) begin
        found     <= 1'b1;
        best_cost <= cost;
        best_idx  <= p1c;
        best_load <= load_rd;
      end
      if (p1c == '0 || load_rd < min_load) begin
        min_idx  <= p1c;
        min_load <= load_rd;
      end
    end
  end

  assign pick      = found ? best_idx : min_idx;
  assign pick_load = found ? best_load : min_load;
  assign new_sum   = {1'b0, pick_load} + (LoadW + 1)'(nnz);
  assign is_changed = (prev >= PrevW'(MaxClusters)) || (prev[CW-1:0] != pick);

  always_ff @(posedge clk) begin
    if (cmd.commit) load_mem[pick] <= new_sum[LoadW] ? {LoadW{1'b1}} : new_sum[LoadW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld   <= '0;
      load_vld  <= '0;
      pass_flag <= 1'b0;
    end else if (in_accept && opcode == OP_START_PASS) begin
      acc_vld   <= '0;
      load_vld  <= '0;
      pass_flag <= 1'b0;
    end else if (cmd.commit) begin
      acc_vld        <= '0;
      load_vld[pick] <= 1'b1;
      if (is_changed) pass_flag <= 1'b1;
    end else if (p2) begin
      acc_vld[c2] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      chosen_cluster <= pick;
      changed        <= is_changed;
      any_changed    <= pass_flag || is_changed;
      forced         <= !found;
      cluster_load   <= new_sum[LoadW] ? {LoadW{1'b1}} : new_sum[LoadW-1:0];
    end
  end

  assign sts.acc_done = p2 && c2 == CW'(MaxClusters - 1);
  assign sts.sel_done = p1 && p1_sel && p1c == k_last;
  assign sts.col_last = col_last;
  assign sts.out_busy = out_valid && !out_ready;

  a_commit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit while a result is still held");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> acc_vld == '0)
    else $error("accumulators not cleared after a selection");

  a_fit_ok: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && found) |-> ({1'b0, best_load} + (LoadW + 1)'(nnz) <= {1'b0, max_capacity}))
    else $error("chosen cluster exceeds the maximum load");

endmodule

FILE: src/capacity_bounded_cluster_assign.sv
// Top level of the capacity-bounded cluster assignment block.
// One item is taken at a time. A centroid load, a start-pass item or an unused
// opcode is taken while idle and leaves the controller idle. A feature element
// walks all 64 clusters through the accumulator memory port and the distance
// pipeline. The last element of a column adds a selection scan over the first
// k clusters of the accumulator and load memories, where k is the active cluster
// count (num_clusters held to 1..64), and a commit. The result waits in an output
// register; the next item is taken meanwhile and only a following commit waits
// for it to be taken.
module capacity_bounded_cluster_assign import cbca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cluster_index[5:0], dim_index[10:6], element_value[26:11], column_nnz[50:27],
  // previous_cluster[57:51], zero fill above
  input  logic [63:0] s_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_tuser,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // chosen_cluster[5:0], changed[6], any_changed[7], forced[8], cluster_load[40:9],
  // zero fill above
  output logic [47:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [6:0]       num_clusters;
  logic [LoadW-1:0] min_capacity, max_capacity;
  logic             in_accept;
  opcode_t          opcode;
  cbca_cmd_t        cmd;
  cbca_sts_t        sts;
  logic [CW-1:0]    chosen_cluster;
  logic             changed, any_changed, forced;
  logic [LoadW-1:0] cluster_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters <= 7'd64;
      min_capacity <= '0;
      max_capacity <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_CLUSTERS: num_clusters <= cfg_data[6:0];
        CFG_MIN_CAPACITY: min_capacity <= cfg_data;
        CFG_MAX_CAPACITY: max_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  assign opcode    = opcode_t'(s_tuser);
  assign in_accept = s_tvalid && s_tready;

  cbca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .opcode    (opcode),
    .sts       (sts),
    .in_ready  (s_tready),
    .cmd       (cmd)
  );

  cbca_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .in_accept        (in_accept),
    .opcode           (opcode),
    .cluster_index    (s_tdata[5:0]),
    .dim_index        (s_tdata[10:6]),
    .element_value    (s_tdata[26:11]),
    .column_nnz       (s_tdata[50:27]),
    .previous_cluster (s_tdata[57:51]),
    .last_element     (s_tlast),
    .num_clusters     (num_clusters),
    .min_capacity     (min_capacity),
    .max_capacity     (max_capacity),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .chosen_cluster   (chosen_cluster),
    .changed          (changed),
    .any_changed      (any_changed),
    .forced           (forced),
    .cluster_load     (cluster_load)
  );

  assign m_tdata = {7'd0, cluster_load, forced, any_changed, changed, chosen_cluster};

endmodule
